// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the over-temperature monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off while in reset.
`define OTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/otm_pkg.sv -----
// Types and constants of the over-temperature monitor.
`default_nettype none

package otm_pkg;

  localparam int ADC_BITS   = 10;
  localparam int THR_W      = 10;
  localparam int DEB_W      = 8;
  localparam int TICK_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_SAFE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DANGER   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 3'd4;

  // Request kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [ADC_BITS-1:0] sample;
    logic                lights_on;
    logic                power_on;
  } in_item_t;

  typedef struct packed {
    logic                fault;
    logic                buzzer_pulse;
    logic                reading_valid;
    logic [ADC_BITS-1:0] reading;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]  safe_threshold;
    logic [THR_W-1:0]  danger_threshold;
    logic [DEB_W-1:0]  debounce_count;
    logic [TICK_W-1:0] idle_ticks;
    logic [TICK_W-1:0] window_ticks;
  } cfg_t;

  typedef struct packed {
    logic enabled;
    logic sampling;
    logic fault;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/over_temperature_monitor.sv -----
// Over-temperature monitor: periodic peak sampling of a thermistor with debounced fault.
//
// Input channel (in_valid/in_ready/in_data) carries one request per item: either a
// period tick or an ADC sample. Every request yields exactly one result on the
// output channel (out_valid/out_ready/out_data): fault flag, buzzer pulse on fault
// clear, and the evaluated peak when a sampling window closes.
// Pipeline: an accepted request sits in the input register; when the output register
// can advance, the core computes the state update and the result is captured in the
// output register, which raises out_valid. Throughput is one request per cycle while
// the receiver does not stall; the state update is a single increment, compare and select between those two.
// When the receiver stalls, the output register holds its result and the input
// register can still take one more request; in_ready drops only when both are full.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr; indexes beyond the
// register list are ignored. Write only while no request is in flight.
// Reset (rst_n low, synchronous) clears both pipeline registers, disables the
// monitor, clears the fault and counters and restores the register defaults.
`default_nettype none
`include "assert_macros.svh"

module over_temperature_monitor (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire otm_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output otm_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [otm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [otm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import otm_pkg::*;

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      advance;
  logic      step;
  out_item_t core_res;
  status_t   core_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_threshold   <= THR_W'(0);
      cfg_r.danger_threshold <= THR_W'(0);
      cfg_r.debounce_count   <= DEB_W'(3);
      cfg_r.idle_ticks       <= TICK_W'(500);
      cfg_r.window_ticks     <= TICK_W'(10);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SAFE:     cfg_r.safe_threshold   <= cfg_wdata[THR_W-1:0];
        REG_DANGER:   cfg_r.danger_threshold <= cfg_wdata[THR_W-1:0];
        REG_DEBOUNCE: cfg_r.debounce_count   <= cfg_wdata[DEB_W-1:0];
        REG_IDLE:     cfg_r.idle_ticks       <= cfg_wdata[TICK_W-1:0];
        REG_WINDOW:   cfg_r.window_ticks     <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  otm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (core_res),
    .status  (core_status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OTM_ASSERT_IMP(a_buzz_needs_fault, clk, rst_n, step && core_res.buzzer_pulse, core_status.fault, "buzzer pulse without an active fault")
  `OTM_ASSERT_NEXT(a_close_ends_window, clk, rst_n, step && core_res.reading_valid, !core_status.sampling, "window still open after a reading")
  `OTM_ASSERT_IMP(a_disabled_quiet, clk, rst_n, !core_status.enabled, !core_status.sampling && !core_status.fault, "window or fault while disabled")

endmodule

`default_nettype wire

// ----- sv/otm_core.sv -----
// Monitor state and the combinational update for one request, registered when step_en is high.
`default_nettype none

module otm_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire otm_pkg::in_item_t item,
  input  wire otm_pkg::cfg_t     cfg,
  output otm_pkg::out_item_t     res,
  output otm_pkg::status_t       status
);
  import otm_pkg::*;

  logic                enabled_r, enabled_nxt;
  logic                sampling_r, sampling_nxt;
  logic [TICK_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [ADC_BITS-1:0] peak_r, peak_nxt;
  logic [DEB_W-1:0]    deb_cnt_r, deb_cnt_nxt;
  logic                fault_r, fault_nxt;

  logic [TICK_W-1:0]   tick_inc;
  logic [DEB_W-1:0]    deb_inc;
  logic                hit;

  assign tick_inc = tick_cnt_r + TICK_W'(1);
  assign deb_inc  = deb_cnt_r + DEB_W'(1);
  // With a fault the peak must recover to safe; without one it must drop to danger
  assign hit = fault_r ? (peak_r >= cfg.safe_threshold) : (peak_r <= cfg.danger_threshold);

  always_comb begin
    enabled_nxt  = enabled_r;
    sampling_nxt = sampling_r;
    tick_cnt_nxt = tick_cnt_r;
    peak_nxt     = peak_r;
    deb_cnt_nxt  = deb_cnt_r;
    fault_nxt    = fault_r;
    res          = '0;

    if (item.operation == OP_SAMPLE) begin
      if (sampling_r && (item.sample != '0) && (item.sample > peak_r)) begin
        peak_nxt = item.sample;
      end
    end else if (!enabled_r) begin
      if (item.power_on) begin
        enabled_nxt = 1'b1;
      end
    end else if (!sampling_r) begin
      if (item.lights_on || fault_r) begin
        if (tick_inc >= cfg.idle_ticks) begin
          tick_cnt_nxt = '0;
          sampling_nxt = 1'b1;
        end else begin
          tick_cnt_nxt = tick_inc;
        end
      end else begin
        tick_cnt_nxt = '0;
      end
    end else begin
      if (tick_inc >= cfg.window_ticks) begin
        tick_cnt_nxt = '0;
        peak_nxt     = '0;
        // an empty window restarts without closing
        if (peak_r != '0) begin
          sampling_nxt      = 1'b0;
          res.reading_valid = 1'b1;
          res.reading       = peak_r;
          if (!hit) begin
            deb_cnt_nxt = '0;
          end else if (deb_inc >= cfg.debounce_count) begin
            deb_cnt_nxt      = '0;
            fault_nxt        = !fault_r;
            res.buzzer_pulse = fault_r;
          end else begin
            deb_cnt_nxt = deb_inc;
          end
        end
      end else begin
        tick_cnt_nxt = tick_inc;
      end
    end

    res.fault = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      sampling_r <= 1'b0;
      tick_cnt_r <= '0;
      peak_r     <= '0;
      deb_cnt_r  <= '0;
      fault_r    <= 1'b0;
    end else if (step_en) begin
      enabled_r  <= enabled_nxt;
      sampling_r <= sampling_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      peak_r     <= peak_nxt;
      deb_cnt_r  <= deb_cnt_nxt;
      fault_r    <= fault_nxt;
    end
  end

  assign status.enabled  = enabled_r;
  assign status.sampling = sampling_r;
  assign status.fault    = fault_r;

endmodule

`default_nettype wire
